[rtl/core/ccsg_pkg.sv]
// Shared constants, types and control structures of the color chain singlet grouper.
`default_nettype none

package ccsg_pkg;

	localparam int TAG_W = 16;
	localparam int POS_W = 6;
	localparam int DEF_MAX_ITEMS = 64;
	localparam int DEF_TAG_BITS = 16;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_TRIPLET,
		KIND_ANTI,
		KIND_OCTET
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_START,
		ST_CLOSE_RD,
		ST_CLOSE_OUT,
		ST_FLUSH,
		ST_FLUSH_RD,
		ST_FLUSH_OUT
	} ctrl_st_t;

	typedef struct packed {
		logic latch;
		logic link;
		logic start;
		logic rd;
		logic emit;
		logic run_end;
		logic set_clear;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic has_chain;
		logic join_ok;
		logic start_ok;
		logic set_end;
		logic drain_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/ccsg_item_if.sv]
// Input channel interface carrying one item per beat.
`default_nettype none

interface ccsg_item_if;
	logic valid;
	logic ready;
	logic [ccsg_pkg::TAG_W-1:0] color_tag;
	logic [ccsg_pkg::TAG_W-1:0] anticolor_tag;
	logic set_end;

	modport source(output valid, output color_tag, output anticolor_tag, output set_end,
		input ready);
	modport sink(input valid, input color_tag, input anticolor_tag, input set_end,
		output ready);
endinterface

`default_nettype wire

[rtl/core/ccsg_result_if.sv]
// Output channel interface carrying one grouped item per beat.
`default_nettype none

interface ccsg_result_if;
	logic valid;
	logic ready;
	logic [ccsg_pkg::POS_W-1:0] item_position;
	logic chain_end;
	logic run_end;

	modport source(output valid, output item_position, output chain_end, output run_end,
		input ready);
	modport sink(input valid, input item_position, input chain_end, input run_end,
		output ready);
endinterface

`default_nettype wire

[rtl/core/color_chain_singlet_grouper.sv]
// Top level of the color chain singlet grouper.
// An item that joins the open chain or is dropped is accepted in the idle state and then
// tested against the open chain ends in the evaluate state. Trying an item as the start of
// a new chain adds the start state. Every result takes a read of the chain memory and then a
// load of the output register, so an item that closes a chain of n items first drains n
// results, and a set end adds the flush state plus a read and a load per item of the chain
// it flushes. A result that waits at the output stalls draining, not the acceptance of the
// next item once the run is complete. The chain memory needs no clearing after reset.
`default_nettype none

module color_chain_singlet_grouper #(
	parameter int MAX_ITEMS = ccsg_pkg::DEF_MAX_ITEMS,
	parameter int TAG_BITS = ccsg_pkg::DEF_TAG_BITS
) (
	input wire logic     clk,
	input wire logic     arst_n,
	ccsg_item_if.sink    item,
	ccsg_result_if.source result
);

	ccsg_pkg::cmd_t cmd;
	ccsg_pkg::sts_t sts;

	ccsg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ccsg_datapath #(
		.MAX_ITEMS (MAX_ITEMS),
		.TAG_BITS  (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.color_tag     (item.color_tag),
		.anticolor_tag (item.anticolor_tag),
		.set_end       (item.set_end),
		.cmd           (cmd),
		.sts           (sts),
		.res_ready     (result.ready),
		.res_valid     (result.valid),
		.res_position  (result.item_position),
		.res_chain_end (result.chain_end),
		.res_run_end   (result.run_end)
	);

endmodule

`default_nettype wire

[rtl/core/ccsg_datapath.sv]
// Datapath: item registers, open chain ends, chain deque memory and result register.
`default_nettype none

module ccsg_datapath #(
	parameter int MAX_ITEMS = ccsg_pkg::DEF_MAX_ITEMS,
	parameter int TAG_BITS = ccsg_pkg::DEF_TAG_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [ccsg_pkg::TAG_W-1:0]     color_tag,
	input  wire logic [ccsg_pkg::TAG_W-1:0]     anticolor_tag,
	input  wire logic                           set_end,
	input  wire ccsg_pkg::cmd_t                 cmd,
	output ccsg_pkg::sts_t                      sts,
	input  wire logic                           res_ready,
	output logic                                res_valid,
	output logic [ccsg_pkg::POS_W-1:0]          res_position,
	output logic                                res_chain_end,
	output logic                                res_run_end
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int LEN_W = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int CMP_W = (TAG_BITS < ccsg_pkg::TAG_W) ? TAG_BITS : ccsg_pkg::TAG_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ITEMS - 1);
	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_ITEMS);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(MAX_ITEMS);

	logic [CMP_W-1:0] color_q;
	logic [CMP_W-1:0] anti_q;
	logic             set_end_q;
	logic [CMP_W-1:0] open_color_q;
	logic [CMP_W-1:0] open_anti_q;
	ccsg_pkg::kind_t  kind_q;
	logic             stopped_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] front_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] drain_q;
	logic [IDX_W-1:0] chain_mem [MAX_ITEMS];
	logic [IDX_W-1:0] rd_data_q;
	logic             res_valid_q;
	logic [ccsg_pkg::POS_W-1:0] res_position_q;
	logic             res_chain_end_q;
	logic             res_run_end_q;

	logic             oc_nz;
	logic             oa_nz;
	logic             hit_front;
	logic             hit_back;
	logic             join_front;
	logic             join_back;
	logic             start_ok;
	ccsg_pkg::kind_t  start_kind;
	logic [SUM_W-1:0] back_sum;
	logic [IDX_W-1:0] back_idx;
	logic [SUM_W-1:0] drain_sum;
	logic [IDX_W-1:0] drain_idx;
	logic [IDX_W-1:0] front_dec;
	logic             can_push;
	logic             drain_last;
	logic             counted;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;

	always_comb begin
		oc_nz = |open_color_q;
		oa_nz = |open_anti_q;
		hit_front = (color_q == open_anti_q);
		hit_back = (anti_q == open_color_q);
		join_front = 1'b0;
		join_back = 1'b0;
		case (kind_q)
			ccsg_pkg::KIND_TRIPLET: join_back = oc_nz && !oa_nz && hit_back;
			ccsg_pkg::KIND_ANTI: join_front = !oc_nz && oa_nz && hit_front;
			ccsg_pkg::KIND_OCTET: begin
				join_front = oc_nz && oa_nz && hit_front;
				join_back = oc_nz && oa_nz && !hit_front && hit_back;
			end
			default: begin
				join_front = 1'b0;
				join_back = 1'b0;
			end
		endcase

		start_ok = (|color_q) || (|anti_q);
		if ((|color_q) && !(|anti_q)) begin
			start_kind = ccsg_pkg::KIND_TRIPLET;
		end else if (!(|color_q) && (|anti_q)) begin
			start_kind = ccsg_pkg::KIND_ANTI;
		end else begin
			start_kind = ccsg_pkg::KIND_OCTET;
		end

		back_sum = SUM_W'(front_q) + SUM_W'(len_q);
		back_idx = (back_sum >= SUM_MAX) ? IDX_W'(back_sum - SUM_MAX) : IDX_W'(back_sum);
		drain_sum = SUM_W'(front_q) + SUM_W'(drain_q);
		drain_idx = (drain_sum >= SUM_MAX) ? IDX_W'(drain_sum - SUM_MAX) : IDX_W'(drain_sum);
		front_dec = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
		can_push = (len_q != FULL_LEN);
		drain_last = ((SUM_W'(drain_q) + SUM_W'(1)) == SUM_W'(len_q));
		counted = cmd.link || (cmd.start && start_ok);

		wr_en = (cmd.link && can_push) || (cmd.start && start_ok);
		if (cmd.start) begin
			wr_addr = '0;
		end else if (join_front) begin
			wr_addr = front_dec;
		end else begin
			wr_addr = back_idx;
		end
	end

	always_comb begin
		sts.active = !stopped_q;
		sts.has_chain = (kind_q != ccsg_pkg::KIND_NONE);
		sts.join_ok = join_front || join_back;
		sts.start_ok = start_ok;
		sts.set_end = set_end_q;
		sts.drain_last = drain_last;
		sts.out_free = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			color_q <= color_tag[CMP_W-1:0];
			anti_q <= anticolor_tag[CMP_W-1:0];
			set_end_q <= set_end;
		end
		if (wr_en) begin
			chain_mem[wr_addr] <= count_q;
		end
		if (cmd.rd) begin
			rd_data_q <= chain_mem[drain_idx];
		end
		if (cmd.emit) begin
			res_position_q <= ccsg_pkg::POS_W'(rd_data_q);
			res_chain_end_q <= drain_last;
			res_run_end_q <= cmd.run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_color_q <= '0;
			open_anti_q <= '0;
			kind_q <= ccsg_pkg::KIND_NONE;
			stopped_q <= 1'b0;
			count_q <= '0;
			front_q <= '0;
			len_q <= '0;
			drain_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.link) begin
				if (join_front) begin
					open_anti_q <= anti_q;
					if (can_push) begin
						front_q <= front_dec;
					end
				end else begin
					open_color_q <= color_q;
				end
				if (can_push) begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			if (cmd.start) begin
				if (start_ok) begin
					kind_q <= start_kind;
					open_color_q <= color_q;
					open_anti_q <= anti_q;
					front_q <= '0;
					len_q <= LEN_W'(1);
				end else begin
					stopped_q <= 1'b1;
				end
			end
			if (counted) begin
				if (count_q == LAST_IDX) begin
					stopped_q <= 1'b1;
				end else begin
					count_q <= count_q + IDX_W'(1);
				end
			end
			if (cmd.emit) begin
				if (drain_last) begin
					kind_q <= ccsg_pkg::KIND_NONE;
					open_color_q <= '0;
					open_anti_q <= '0;
					front_q <= '0;
					len_q <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + IDX_W'(1);
				end
			end
			if (cmd.set_clear) begin
				stopped_q <= 1'b0;
				count_q <= '0;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_position = res_position_q;
	assign res_chain_end = res_chain_end_q;
	assign res_run_end = res_run_end_q;

endmodule

`default_nettype wire

[rtl/core/ccsg_ctrl.sv]
// Controller state machine sequencing evaluation, chain start and chain draining.
`default_nettype none

module ccsg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire ccsg_pkg::sts_t  sts,
	output ccsg_pkg::cmd_t       cmd
);

	ccsg_pkg::ctrl_st_t state_q;
	ccsg_pkg::ctrl_st_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ccsg_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_nxt = ccsg_pkg::ST_EVAL;
				end
			end
			ccsg_pkg::ST_EVAL: begin
				if (!sts.active || (sts.has_chain && sts.join_ok)) begin
					state_nxt = sts.set_end ? ccsg_pkg::ST_FLUSH : ccsg_pkg::ST_IDLE;
				end else if (sts.has_chain) begin
					state_nxt = ccsg_pkg::ST_CLOSE_RD;
				end else begin
					state_nxt = ccsg_pkg::ST_START;
				end
			end
			ccsg_pkg::ST_START: begin
				state_nxt = sts.set_end ? ccsg_pkg::ST_FLUSH : ccsg_pkg::ST_IDLE;
			end
			ccsg_pkg::ST_CLOSE_RD: state_nxt = ccsg_pkg::ST_CLOSE_OUT;
			ccsg_pkg::ST_CLOSE_OUT: begin
				if (sts.out_free) begin
					state_nxt = sts.drain_last ? ccsg_pkg::ST_START : ccsg_pkg::ST_CLOSE_RD;
				end
			end
			ccsg_pkg::ST_FLUSH: begin
				state_nxt = sts.has_chain ? ccsg_pkg::ST_FLUSH_RD : ccsg_pkg::ST_IDLE;
			end
			ccsg_pkg::ST_FLUSH_RD: state_nxt = ccsg_pkg::ST_FLUSH_OUT;
			ccsg_pkg::ST_FLUSH_OUT: begin
				if (sts.out_free) begin
					state_nxt = sts.drain_last ? ccsg_pkg::ST_IDLE : ccsg_pkg::ST_FLUSH_RD;
				end
			end
			default: state_nxt = ccsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			ccsg_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.latch = item_valid;
			end
			ccsg_pkg::ST_EVAL: cmd.link = sts.active && sts.has_chain && sts.join_ok;
			ccsg_pkg::ST_START: cmd.start = 1'b1;
			ccsg_pkg::ST_CLOSE_RD: cmd.rd = 1'b1;
			ccsg_pkg::ST_CLOSE_OUT: begin
				cmd.emit = sts.out_free;
				cmd.run_end = sts.drain_last && !(sts.set_end && sts.start_ok);
			end
			ccsg_pkg::ST_FLUSH: cmd.set_clear = !sts.has_chain;
			ccsg_pkg::ST_FLUSH_RD: cmd.rd = 1'b1;
			ccsg_pkg::ST_FLUSH_OUT: begin
				cmd.emit = sts.out_free;
				cmd.run_end = sts.drain_last;
				cmd.set_clear = sts.out_free && sts.drain_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/ccsg_checker.sv]
// Port-level checker for the color chain singlet grouper and its bind statement.
`default_nettype none

module ccsg_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [ccsg_pkg::POS_W-1:0]  out_position,
	input wire logic                        out_chain_end,
	input wire logic                        out_run_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result beat dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_position) && $stable(out_chain_end)
			&& $stable(out_run_end))
		else $error("Result beat changed while stalled.");

	a_run_closes_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_run_end |-> out_chain_end)
		else $error("Run ended in the middle of a chain.");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_run_end |-> !in_ready)
		else $error("Input taken before the run of results was complete.");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken on two cycles in a row.");

endmodule

bind color_chain_singlet_grouper ccsg_checker u_ccsg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_position  (result.item_position),
	.out_chain_end (result.chain_end),
	.out_run_end   (result.run_end)
);

`default_nettype wire
